// ----- hw/rtl/mdpg_pkg.sv -----
// Package for the mouse delta packet generator: operation codes,
// register indexes, reset values and status byte bit positions.
// No dependencies.
package mdpg_pkg;

	typedef enum logic [2:0] {
		OP_NOTE_ON  = 3'd0,
		OP_NOTE_OFF = 3'd1,
		OP_CC       = 3'd2,
		OP_REQUEST  = 3'd3,
		OP_RELEASE  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		REG_LEFT_NOTE    = 2'd0,
		REG_RIGHT_NOTE   = 2'd1,
		REG_X_CONTROLLER = 2'd2,
		REG_Y_CONTROLLER = 2'd3
	} reg_idx_t;

	localparam int unsigned NUM_W   = 7;
	localparam int unsigned ACC_W   = 16;
	localparam int unsigned BYTE_W  = 8;

	localparam logic [NUM_W-1:0] LEFT_NOTE_RST    = 7'd0;
	localparam logic [NUM_W-1:0] RIGHT_NOTE_RST   = 7'd1;
	localparam logic [NUM_W-1:0] X_CONTROLLER_RST = 7'h30;
	localparam logic [NUM_W-1:0] Y_CONTROLLER_RST = 7'h31;

	localparam logic [BYTE_W-1:0] DELTA_ZERO = 8'd64;

	localparam logic [1:0] BTN_L = 2'b01;
	localparam logic [1:0] BTN_R = 2'b10;

	// Byte position within a packet.
	typedef enum logic [1:0] {
		POS_STATUS = 2'd0,
		POS_X      = 2'd1,
		POS_Y      = 2'd2
	} pos_t;

endpackage

// ----- hw/rtl/mouse_delta_packet_generator.sv -----
// Mouse delta packet generator top level: input register, state update
// and a three-byte packet buffer feeding the output channel.
// Depends on mdpg_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one event item: operation,
//   note, controller, delta_code and request. Button press/release and
//   release-all items update the button bits, controller items add
//   delta_code - 64 to the X or Y accumulator (saturating at 16 bits).
//   A request item whose bit 0 falls from 1 to 0 produces a packet of three
//   output items: status, X and Y, each clamped X/Y byte being subtracted
//   from its accumulator. The output item with last high ends the packet.
//   Configuration channel (cfg_valid/cfg_ready) writes note and controller
//   numbers; cfg_ready is always high. Write only while the block is idle.
// Order: an item enters the input register at acceptance and updates the
//   state as it leaves, when a packet item also loads the packet buffer.
// Throughput: one item per cycle; a packet-producing item waits in the
//   input register until the packet buffer has drained (three output
//   transfers).
// Reset: clears the buttons and accumulators, sets the previous request
//   bit to one and loads the default register values.
// Stall: when out_ready is low the current byte holds; events that make no
//   packet keep flowing until a second packet is pending.
module mouse_delta_packet_generator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] operation,
	input  logic [6:0] note,
	input  logic [6:0] controller,
	input  logic [6:0] delta_code,
	input  logic [7:0] request,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] packet_byte,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data
);

	localparam int unsigned NW = mdpg_pkg::NUM_W;
	localparam int unsigned AW = mdpg_pkg::ACC_W;
	localparam int unsigned BW = mdpg_pkg::BYTE_W;

	// Configuration registers
	logic [NW-1:0] left_note_q, right_note_q, x_ctl_q, y_ctl_q;

	// Input register
	logic          valid_s1;
	logic [2:0]    operation_s1;
	logic [NW-1:0] note_s1, controller_s1, delta_code_s1;
	logic          req_bit_s1;

	// Block state
	logic [1:0]    buttons_q;
	logic [AW-1:0] x_acc_q, y_acc_q;
	logic          prev_req_q;

	// Packet buffer
	logic          pkt_valid_q;
	mdpg_pkg::pos_t pos_q;
	logic [BW-1:0] status_q, x_byte_q, y_byte_q;

	// Combinational update
	logic [1:0]    btn_sel;
	logic [BW-1:0] delta;
	logic [AW-1:0] x_sum, y_sum;
	logic          falling, has_packet, pkt_free, advance;
	logic          x_over, x_under, y_over, y_under;
	logic [BW-1:0] x_clamp, y_clamp;
	logic [BW-1:0] status_n;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_note_q  <= mdpg_pkg::LEFT_NOTE_RST;
			right_note_q <= mdpg_pkg::RIGHT_NOTE_RST;
			x_ctl_q      <= mdpg_pkg::X_CONTROLLER_RST;
			y_ctl_q      <= mdpg_pkg::Y_CONTROLLER_RST;
		end else if (cfg_valid) begin
			unique case (mdpg_pkg::reg_idx_t'(cfg_index))
				mdpg_pkg::REG_LEFT_NOTE:    left_note_q  <= cfg_data;
				mdpg_pkg::REG_RIGHT_NOTE:   right_note_q <= cfg_data;
				mdpg_pkg::REG_X_CONTROLLER: x_ctl_q      <= cfg_data;
				mdpg_pkg::REG_Y_CONTROLLER: y_ctl_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturating add of a signed delta to a 16-bit accumulator.
	function automatic logic [AW-1:0] sat_add(logic [AW-1:0] acc, logic [BW-1:0] d);
		logic [AW:0] s;
		s = {acc[AW-1], acc} + {{(AW+1-BW){d[BW-1]}}, d};
		if (s[AW] != s[AW-1])
			sat_add = s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
		else
			sat_add = s[AW-1:0];
	endfunction

	// Right button wins when both notes match.
	always_comb begin
		if (note_s1 == right_note_q)
			btn_sel = mdpg_pkg::BTN_R;
		else if (note_s1 == left_note_q)
			btn_sel = mdpg_pkg::BTN_L;
		else
			btn_sel = 2'b00;
	end

	assign delta = {1'b0, delta_code_s1} - mdpg_pkg::DELTA_ZERO;
	assign x_sum = sat_add(x_acc_q, delta);
	assign y_sum = sat_add(y_acc_q, delta);

	// Clamp to one signed byte and flag the direction of the excess.
	assign x_over  = !x_acc_q[AW-1] && (|x_acc_q[AW-2:BW-1]);
	assign x_under =  x_acc_q[AW-1] && !(&x_acc_q[AW-2:BW-1]);
	assign y_over  = !y_acc_q[AW-1] && (|y_acc_q[AW-2:BW-1]);
	assign y_under =  y_acc_q[AW-1] && !(&y_acc_q[AW-2:BW-1]);

	assign x_clamp = x_over ? {1'b0, {(BW-1){1'b1}}} :
		x_under ? {1'b1, {(BW-1){1'b0}}} : x_acc_q[BW-1:0];
	assign y_clamp = y_over ? {1'b0, {(BW-1){1'b1}}} :
		y_under ? {1'b1, {(BW-1){1'b0}}} : y_acc_q[BW-1:0];

	assign status_n = {y_under, y_over, x_under, x_over, 2'b00, buttons_q};

	assign falling    = prev_req_q && !req_bit_s1;
	assign has_packet = (mdpg_pkg::op_t'(operation_s1) == mdpg_pkg::OP_REQUEST) && falling;
	assign pkt_free   = !pkt_valid_q || (out_ready && pos_q == mdpg_pkg::POS_Y);
	// Hold a packet-producing item until the buffer can take its bytes.
	assign advance    = valid_s1 && (!has_packet || pkt_free);
	assign in_ready   = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			operation_s1  <= operation;
			note_s1       <= note;
			controller_s1 <= controller;
			delta_code_s1 <= delta_code;
			req_bit_s1    <= request[0];
		end
	end

	// State update as the registered item leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buttons_q  <= 2'b00;
			x_acc_q    <= '0;
			y_acc_q    <= '0;
			prev_req_q <= 1'b1;
		end else if (advance) begin
			case (mdpg_pkg::op_t'(operation_s1))
				mdpg_pkg::OP_NOTE_ON:  buttons_q <= buttons_q | btn_sel;
				mdpg_pkg::OP_NOTE_OFF: buttons_q <= buttons_q & ~btn_sel;
				mdpg_pkg::OP_RELEASE:  buttons_q <= 2'b00;
				mdpg_pkg::OP_CC: begin
					// X wins when both controllers match.
					if (controller_s1 == x_ctl_q)
						x_acc_q <= x_sum;
					else if (controller_s1 == y_ctl_q)
						y_acc_q <= y_sum;
				end
				mdpg_pkg::OP_REQUEST: begin
					prev_req_q <= req_bit_s1;
					if (falling) begin
						// Carry the excess over to the next packet.
						x_acc_q <= x_acc_q - {{(AW-BW){x_clamp[BW-1]}}, x_clamp};
						y_acc_q <= y_acc_q - {{(AW-BW){y_clamp[BW-1]}}, y_clamp};
					end
				end
				default: ;
			endcase
		end
	end

	// Packet buffer and byte sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid_q <= 1'b0;
			pos_q       <= mdpg_pkg::POS_STATUS;
		end else if (advance && has_packet) begin
			pkt_valid_q <= 1'b1;
			pos_q       <= mdpg_pkg::POS_STATUS;
		end else if (pkt_valid_q && out_ready) begin
			unique case (pos_q)
				mdpg_pkg::POS_STATUS: pos_q <= mdpg_pkg::POS_X;
				mdpg_pkg::POS_X:      pos_q <= mdpg_pkg::POS_Y;
				default: begin
					pos_q       <= mdpg_pkg::POS_STATUS;
					pkt_valid_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_packet) begin
			status_q <= status_n;
			x_byte_q <= x_clamp;
			y_byte_q <= y_clamp;
		end
	end

	assign out_valid = pkt_valid_q;
	assign last      = (pos_q == mdpg_pkg::POS_Y);

	always_comb begin
		case (pos_q)
			mdpg_pkg::POS_STATUS: packet_byte = status_q;
			mdpg_pkg::POS_X:      packet_byte = x_byte_q;
			default:              packet_byte = y_byte_q;
		endcase
	end

endmodule

// ----- hw/rtl/mdpg_checker.sv -----
// Port-level checker for the mouse delta packet generator, bound to the
// top level. Depends on the top level's ports only.
module mdpg_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] packet_byte,
	input logic       last
);

	// A stalled byte holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(packet_byte) && $stable(last))
		else $error("output item changed while stalled");

	// A packet continues after any byte that is not the last.
	a_pkt_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("packet ended before its last byte");

	// A new packet never starts on its last byte.
	a_pkt_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> !(out_valid && last))
		else $error("packet started on a last byte");

	// With nothing to send the input side never stalls.
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty packet buffer");

endmodule

bind mouse_delta_packet_generator mdpg_port_checker u_mdpg_port_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.packet_byte (packet_byte),
	.last        (last)
);
